[hdl/srg_pkg.sv]
// ----------------------------------------------------------------------------
// srg_pkg
// Shared constants, types and helper functions of the subtractive generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned TABLE_DEPTH = 56;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SAMPLE_W    = 31;
  localparam int unsigned PROD_W      = 2 * SAMPLE_W;

  localparam logic [IDX_W-1:0] FILL_LEN        = 6'd55;
  localparam logic [IDX_W-1:0] FILL_STRIDE     = 6'd21;
  localparam logic [IDX_W-1:0] MIX_OFFSET      = 6'd30;
  localparam logic [IDX_W-1:0] FILL_LAST_STEP  = 6'd54;
  localparam logic [1:0]       LAST_PASS       = 2'd3;

  localparam logic [WORD_W-1:0] MODULUS    = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] MODULUS_X2 = 32'hFFFF_FFFE;
  localparam logic [WORD_W-1:0] BASE_SEED  = 32'd161803398;
  localparam logic [WORD_W-1:0] SEED_MIN   = 32'h8000_0000;

  // request kinds
  localparam logic REQ_RESEED = 1'b0;
  localparam logic REQ_DRAW   = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_DRAW    = 2'd0;
  localparam logic [1:0] STATUS_RESEED  = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEED,
    OP_FILL,
    OP_MIX_RD_A,
    OP_MIX_RD_B,
    OP_MIX_WR,
    OP_DRAW_RD_A,
    OP_DRAW_RD_B,
    OP_DRAW_WR,
    OP_MUL,
    OP_PUT_DRAW,
    OP_PUT_RESEED,
    OP_PUT_REFUSED
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } srg_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic mix_last;
  } srg_stat_t;

  // add the modulus back when the difference went negative
  function automatic logic [WORD_W-1:0] fix_neg(input logic [WORD_W-1:0] v);
    fix_neg = v[WORD_W-1] ? (v + MODULUS) : v;
  endfunction

  // lag index step, wraps from the table end to 1
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
    next_index = (idx >= FILL_LEN) ? IDX_W'(1) : (idx + IDX_W'(1));
  endfunction

endpackage

[hdl/srg_req_if.sv]
// ----------------------------------------------------------------------------
// srg_req_if
// Request channel: reseed or draw, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srg_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] seed;
  logic        [30:0] max_value;

  modport source (output valid, output req_type, output seed, output max_value,
                  input ready);
  modport sink   (input valid, input req_type, input seed, input max_value,
                  output ready);
endinterface

[hdl/srg_rsp_if.sv]
// ----------------------------------------------------------------------------
// srg_rsp_if
// Result channel: status and samples, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srg_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [30:0] raw_sample;
  logic [30:0] scaled_sample;

  modport source (output valid, output status, output raw_sample,
                  output scaled_sample, input ready);
  modport sink   (input valid, input status, input raw_sample,
                  input scaled_sample, output ready);
endinterface

[hdl/subtractive_random_generator.sv]
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Lagged subtractive random generator with 56-entry lag table, reseed and
// draw requests, raw and range-scaled samples.
// ----------------------------------------------------------------------------
//   channel | dir | payload                               | handshake
//   req_i   | in  | req_type, seed, max_value             | valid/ready
//   rsp_o   | out | status, raw_sample, scaled_sample     | valid/ready
//
// One request at a time. From transfer to result, a draw performs
// two reads and a write-back through the single-port lag table, then a
// multiply stage; the constant divide folds into the result register load.
// A reseed performs 55 table writes for the fill, then 4 x 55 mixing
// steps, each of two reads and a write-back.
// Reset clears control, indices and the seeded flag; the table is only
// meaningful after a reseed. A stalled result is held in the output
// register; the next request is taken and worked on meanwhile.
// ----------------------------------------------------------------------------
module subtractive_random_generator import srg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  srg_req_if.sink    req_i,
  srg_rsp_if.source  rsp_o
);

  srg_cmd_t  cmd;
  srg_stat_t stat;

  srg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  srg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .seed_i          (req_i.seed),
    .max_value_i     (req_i.max_value),
    .status_o        (rsp_o.status),
    .raw_sample_o    (rsp_o.raw_sample),
    .scaled_sample_o (rsp_o.scaled_sample)
  );

endmodule

[hdl/srg_ram.sv]
// ----------------------------------------------------------------------------
// srg_ram
// Generic single-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module srg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/srg_ctrl.sv]
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer: reseed fill and mixing passes, draw steps, result handoff.
// ----------------------------------------------------------------------------
module srg_ctrl import srg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  logic      req_type_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  srg_stat_t stat_i,
  output srg_cmd_t  cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE        = 13'b0_0000_0000_0001,
    S_SEED        = 13'b0_0000_0000_0010,
    S_FILL        = 13'b0_0000_0000_0100,
    S_MRD_A       = 13'b0_0000_0000_1000,
    S_MRD_B       = 13'b0_0000_0001_0000,
    S_MWR         = 13'b0_0000_0010_0000,
    S_DRD_A       = 13'b0_0000_0100_0000,
    S_DRD_B       = 13'b0_0000_1000_0000,
    S_DWR         = 13'b0_0001_0000_0000,
    S_MUL         = 13'b0_0010_0000_0000,
    S_PUT_DRAW    = 13'b0_0100_0000_0000,
    S_PUT_RESEED  = 13'b0_1000_0000_0000,
    S_PUT_REFUSED = 13'b1_0000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   seeded_q, seeded_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  // output register may be reloaded once its current result is taken
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    seeded_d    = seeded_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o.op    = OP_NONE;
    req_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (req_type_i == REQ_RESEED) begin
            state_d = S_SEED;
          end else if (seeded_q) begin
            state_d = S_DRD_A;
          end else begin
            state_d = S_PUT_REFUSED;
          end
        end
      end
      S_SEED: begin
        cmd_o.op = OP_SEED;
        seeded_d = 1'b1;
        state_d  = S_FILL;
      end
      S_FILL: begin
        cmd_o.op = OP_FILL;
        if (stat_i.fill_last) begin
          state_d = S_MRD_A;
        end
      end
      S_MRD_A: begin
        cmd_o.op = OP_MIX_RD_A;
        state_d  = S_MRD_B;
      end
      S_MRD_B: begin
        cmd_o.op = OP_MIX_RD_B;
        state_d  = S_MWR;
      end
      S_MWR: begin
        cmd_o.op = OP_MIX_WR;
        state_d  = stat_i.mix_last ? S_PUT_RESEED : S_MRD_A;
      end
      S_DRD_A: begin
        cmd_o.op = OP_DRAW_RD_A;
        state_d  = S_DRD_B;
      end
      S_DRD_B: begin
        cmd_o.op = OP_DRAW_RD_B;
        state_d  = S_DWR;
      end
      S_DWR: begin
        cmd_o.op = OP_DRAW_WR;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_PUT_DRAW;
      end
      S_PUT_DRAW: begin
        if (out_free) begin
          cmd_o.op    = OP_PUT_DRAW;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_PUT_RESEED: begin
        if (out_free) begin
          cmd_o.op    = OP_PUT_RESEED;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_PUT_REFUSED: begin
        if (out_free) begin
          cmd_o.op    = OP_PUT_REFUSED;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seeded_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

[hdl/srg_dp.sv]
// ----------------------------------------------------------------------------
// srg_dp
// Datapath: lag table memory, fill/mix counters, lag indices, subtract and
// fixup, sample scaling by multiply and constant division, result register.
// ----------------------------------------------------------------------------
module srg_dp import srg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  srg_cmd_t                cmd_i,
  output srg_stat_t               stat_o,
  input  logic signed [WORD_W-1:0] seed_i,
  input  logic [SAMPLE_W-1:0]     max_value_i,
  output logic [1:0]              status_o,
  output logic [SAMPLE_W-1:0]     raw_sample_o,
  output logic [SAMPLE_W-1:0]     scaled_sample_o
);

  // working registers
  logic [WORD_W-1:0]   seed_q;
  logic [SAMPLE_W-1:0] max_q;
  logic [WORD_W-1:0]   mj_q, mk_q;
  logic [IDX_W-1:0]    pos_q, cnt_q, mix_i_q;
  logic [1:0]          pass_q;
  logic [IDX_W-1:0]    near_q, far_q;
  logic [WORD_W-1:0]   ta_q;
  logic [SAMPLE_W-1:0] raw_q;
  logic [PROD_W-1:0]   prod_q;
  logic [1:0]          out_status_q;
  logic [SAMPLE_W-1:0] out_raw_q, out_scaled_q;

  // memory port
  logic                ram_we;
  logic [IDX_W-1:0]    ram_addr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;

  logic [WORD_W-1:0]   seed_mag, mj_init;
  logic [IDX_W:0]      pos_sum, mix_sum;
  logic [IDX_W-1:0]    pos_next, mix_j;
  logic [IDX_W-1:0]    near_next, far_next;
  logic [WORD_W-1:0]   mix_val, draw_diff, draw_val;
  logic [SAMPLE_W-1:0] prod_hi, prod_lo, scaled;
  logic [WORD_W-1:0]   part_sum;
  logic [1:0]          quot_adj;

  srg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // most negative seed takes the largest positive magnitude
  always_comb begin
    if (seed_q == SEED_MIN) begin
      seed_mag = MODULUS;
    end else if (seed_q[WORD_W-1]) begin
      seed_mag = WORD_W'(0) - seed_q;
    end else begin
      seed_mag = seed_q;
    end
  end
  assign mj_init = BASE_SEED - seed_mag;

  // fill position steps by the stride modulo the fill length
  assign pos_sum  = {1'b0, pos_q} + {1'b0, FILL_STRIDE};
  assign pos_next = (pos_sum >= {1'b0, FILL_LEN}) ? IDX_W'(pos_sum - {1'b0, FILL_LEN})
                                                  : IDX_W'(pos_sum);

  // mixing partner: 1 + ((i + 30) mod 55)
  assign mix_sum = {1'b0, mix_i_q} + {1'b0, MIX_OFFSET};
  assign mix_j   = (mix_sum >= {1'b0, FILL_LEN})
                 ? IDX_W'(mix_sum - {1'b0, FILL_LEN}) + IDX_W'(1)
                 : IDX_W'(mix_sum) + IDX_W'(1);

  assign near_next = next_index(near_q);
  assign far_next  = next_index(far_q);

  assign mix_val   = fix_neg(ta_q - ram_rdata);
  assign draw_diff = ta_q - ram_rdata;
  assign draw_val  = fix_neg((draw_diff == MODULUS) ? (MODULUS - WORD_W'(1)) : draw_diff);

  // floor(p / (2^31-1)): p = hi*2^31 + lo = hi*M + (hi + lo), hi + lo < 2M+2
  assign prod_hi  = prod_q[PROD_W-1:SAMPLE_W];
  assign prod_lo  = prod_q[SAMPLE_W-1:0];
  assign part_sum = {1'b0, prod_hi} + {1'b0, prod_lo};
  always_comb begin
    if (part_sum >= MODULUS_X2) begin
      quot_adj = 2'd2;
    end else if (part_sum >= MODULUS) begin
      quot_adj = 2'd1;
    end else begin
      quot_adj = 2'd0;
    end
  end
  assign scaled = prod_hi + SAMPLE_W'(quot_adj);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = mix_i_q;
    ram_wdata = mix_val;
    case (cmd_i.op)
      OP_SEED: begin
        ram_we    = 1'b1;
        ram_addr  = FILL_LEN;
        ram_wdata = mj_init;
      end
      OP_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = pos_next;
        ram_wdata = mk_q;
      end
      OP_MIX_RD_A: ram_addr = mix_i_q;
      OP_MIX_RD_B: ram_addr = mix_j;
      OP_MIX_WR: begin
        ram_we    = 1'b1;
        ram_addr  = mix_i_q;
        ram_wdata = mix_val;
      end
      OP_DRAW_RD_A: ram_addr = near_next;
      OP_DRAW_RD_B: ram_addr = far_next;
      OP_DRAW_WR: begin
        ram_we    = 1'b1;
        ram_addr  = near_next;
        ram_wdata = draw_val;
      end
      default: ;
    endcase
  end

  assign stat_o.fill_last = (cnt_q == FILL_LAST_STEP);
  assign stat_o.mix_last  = (mix_i_q == FILL_LEN) && (pass_q == LAST_PASS);

  // lag indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= '0;
      far_q  <= FILL_STRIDE;
    end else if (cmd_i.op == OP_SEED) begin
      near_q <= '0;
      far_q  <= FILL_STRIDE;
    end else if (cmd_i.op == OP_DRAW_WR) begin
      near_q <= near_next;
      far_q  <= far_next;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        seed_q <= seed_i;
        max_q  <= max_value_i;
      end
      OP_SEED: begin
        mj_q    <= mj_init;
        mk_q    <= WORD_W'(1);
        pos_q   <= '0;
        cnt_q   <= IDX_W'(1);
        mix_i_q <= IDX_W'(1);
        pass_q  <= '0;
      end
      OP_FILL: begin
        pos_q <= pos_next;
        mk_q  <= fix_neg(mj_q - mk_q);
        mj_q  <= mk_q;
        cnt_q <= cnt_q + IDX_W'(1);
      end
      OP_MIX_RD_B, OP_DRAW_RD_B: ta_q <= ram_rdata;
      OP_MIX_WR: begin
        if (mix_i_q == FILL_LEN) begin
          mix_i_q <= IDX_W'(1);
          pass_q  <= pass_q + 2'd1;
        end else begin
          mix_i_q <= mix_i_q + IDX_W'(1);
        end
      end
      OP_DRAW_WR: raw_q <= draw_val[SAMPLE_W-1:0];
      OP_MUL:     prod_q <= PROD_W'(raw_q) * PROD_W'(max_q);
      OP_PUT_DRAW: begin
        out_status_q <= STATUS_DRAW;
        out_raw_q    <= raw_q;
        out_scaled_q <= scaled;
      end
      OP_PUT_RESEED: begin
        out_status_q <= STATUS_RESEED;
        out_raw_q    <= '0;
        out_scaled_q <= '0;
      end
      OP_PUT_REFUSED: begin
        out_status_q <= STATUS_REFUSED;
        out_raw_q    <= '0;
        out_scaled_q <= '0;
      end
      default: ;
    endcase
  end

  assign status_o        = out_status_q;
  assign raw_sample_o    = out_raw_q;
  assign scaled_sample_o = out_scaled_q;

endmodule
